// ===== hdl/bct_pkg.sv =====
// bct_pkg: shared types, constants and helpers for the contour tracer
// used by bct_quad_fetch and bitmap_contour_tracer; depends on nothing
`default_nettype none

package bct_pkg;

  // mask store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COORD_W    = 9;
  localparam int XIDX_W     = $clog2(MAX_WIDTH);
  localparam int YIDX_W     = $clog2(MAX_HEIGHT);
  localparam int MASK_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int MASK_AW    = $clog2(MASK_DEPTH);

  // corner steps allowed in one next command before giving up
  localparam int STEP_LIMIT = MAX_WIDTH + MAX_HEIGHT + 4;
  localparam int STEP_CNT_W = $clog2(STEP_LIMIT + 1);

  // beat layout
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_START  = 2'd1,
    CMD_NEXT   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_HEADING  = 3'd1,
    ST_OFF_GRID    = 3'd2,
    ST_WRONG_SIDE  = 3'd3,
    ST_NOT_TRACING = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    HEAD_UP    = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_DOWN  = 2'd2,
    HEAD_LEFT  = 2'd3
  } heading_t;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_t;

  // quad lookup request: corner plus the grid window in use
  typedef struct packed {
    logic               go;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
  } quad_req_t;

  typedef struct packed {
    logic       done;
    logic [3:0] quad;
  } quad_rsp_t;

  typedef struct packed {
    logic              en;
    logic [XIDX_W-1:0] x;
    logic [YIDX_W-1:0] y;
    logic              pix;
  } mask_wr_t;

  // quad seen from heading d: bit i takes quad bit (i + d) mod 4
  function automatic logic [3:0] rotate_quad(input logic [3:0] q, input logic [1:0] d);
    logic [7:0] dbl;
    dbl = {q, q} >> d;
    return dbl[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bct_quad_fetch.sv =====
// bct_quad_fetch: one-bit mask memory and the four-read quad sequencer
// depends on bct_pkg
`default_nettype none

module bct_quad_fetch (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bct_pkg::quad_req_t req,
  input  wire bct_pkg::mask_wr_t  wr,
  output bct_pkg::quad_rsp_t      rsp
);

  logic mask_mem [0:bct_pkg::MASK_DEPTH-1];

  logic                        busy;
  logic [2:0]                  phase;
  logic [bct_pkg::COORD_W-1:0] cx;
  logic [bct_pkg::COORD_W-1:0] cy;
  logic [bct_pkg::COORD_W-1:0] w;
  logic [bct_pkg::COORD_W-1:0] h;
  logic                        rd_ok;
  logic                        rd_data;
  logic [3:0]                  quad;
  logic                        done;

  logic                        dx;
  logic                        dy;
  logic [bct_pkg::COORD_W:0]   px;
  logic [bct_pkg::COORD_W:0]   py;
  logic                        in_grid;
  logic [bct_pkg::MASK_AW-1:0] rd_addr;
  logic [bct_pkg::MASK_AW-1:0] wr_addr;
  logic [1:0]                  cap_idx;

  // pixel order: upper left, upper right, lower right, lower left
  assign dx = (phase == 3'd0) || (phase == 3'd3);
  assign dy = (phase == 3'd0) || (phase == 3'd1);
  assign px = {1'b0, cx} - {{bct_pkg::COORD_W{1'b0}}, dx};
  assign py = {1'b0, cy} - {{bct_pkg::COORD_W{1'b0}}, dy};

  assign in_grid = !px[bct_pkg::COORD_W] && !py[bct_pkg::COORD_W] &&
                   (px[bct_pkg::COORD_W-1:0] < w) && (py[bct_pkg::COORD_W-1:0] < h);

  assign rd_addr = bct_pkg::MASK_AW'(py[bct_pkg::YIDX_W-1:0]) *
                   bct_pkg::MASK_AW'(bct_pkg::MAX_WIDTH) +
                   bct_pkg::MASK_AW'(px[bct_pkg::XIDX_W-1:0]);
  assign wr_addr = bct_pkg::MASK_AW'(wr.y) * bct_pkg::MASK_AW'(bct_pkg::MAX_WIDTH) +
                   bct_pkg::MASK_AW'(wr.x);

  assign cap_idx = 2'(phase - 3'd1);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mask_mem[wr_addr] <= wr.pix;
    end
    rd_data <= mask_mem[rd_addr];
    rd_ok   <= in_grid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 3'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.go) begin
        busy  <= 1'b1;
        phase <= 3'd0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && req.go) begin
      cx <= req.x;
      cy <= req.y;
      w  <= req.width;
      h  <= req.height;
    end
    // read data is registered, so each capture belongs to the address of the previous phase
    if (busy && (phase != 3'd0)) begin
      quad[cap_idx] <= rd_data & rd_ok;
    end
  end

  assign rsp.done = done;
  assign rsp.quad = quad;

endmodule

`default_nettype wire

// ===== hdl/bitmap_contour_tracer.sv =====
// bitmap_contour_tracer: corner-walking boundary follower over a one-bit mask
// depends on bct_pkg and bct_quad_fetch
// write pixel: no result beat. start: one result beat, after a quad lookup when on grid.
// next: per corner walked a step, lookup issue, four serial mask reads on the single
// read port and a decision, until a turn or the walk ends; then the result beat is emitted.
// one command at a time; writes are taken while a result beat waits.
// rst (synchronous) clears control state; the mask memory is not cleared.
`default_nettype none

module bitmap_contour_tracer (
  input  wire logic        clk,
  input  wire logic        rst,
  // command beats
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // x_coord[8:0], y_coord[17:9], pixel_bit[18], target_color[19]
  input  wire logic [1:0]  s_tuser,  // command[1:0]
  // result beats
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // vertex_x[8:0], vertex_y[17:9]
  output logic             m_tlast,  // ring_done
  output logic [2:0]       m_tuser,  // status[2:0]
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  localparam int CW = bct_pkg::COORD_W;

  bct_pkg::state_t state;
  bct_pkg::state_t state_next;

  // configuration
  logic [CW-1:0] grid_width;
  logic [CW-1:0] grid_height;
  logic [CW-1:0] eff_w;
  logic [CW-1:0] eff_h;

  // walk state
  logic [CW-1:0]                  walk_x;
  logic [CW-1:0]                  walk_y;
  logic [CW-1:0]                  origin_x;
  logic [CW-1:0]                  origin_y;
  logic [1:0]                     heading;
  logic                           tracing_active;
  logic                           traced_color;
  logic                           is_start;
  logic [bct_pkg::STEP_CNT_W-1:0] step_cnt;

  // pending result, then the output register
  logic [CW-1:0]     res_x;
  logic [CW-1:0]     res_y;
  logic              res_done;
  bct_pkg::status_t  res_status;
  logic [CW-1:0]     out_x;
  logic [CW-1:0]     out_y;
  logic              out_done;
  bct_pkg::status_t  out_status;
  logic              out_valid;
  logic              out_free;
  logic              out_load;

  // decoded command beat
  bct_pkg::cmd_t in_cmd;
  logic [CW-1:0] in_x;
  logic [CW-1:0] in_y;
  logic          in_pix;
  logic          in_color;
  logic          accept;
  logic          start_off;

  // corner step
  logic [CW:0] cand_x;
  logic [CW:0] cand_y;
  logic        at_origin;
  logic        cand_off;

  // quad decisions
  bct_pkg::quad_req_t qreq;
  bct_pkg::quad_rsp_t qrsp;
  bct_pkg::mask_wr_t  mwr;
  logic [3:0]         qc;
  logic [3:0]         rot;
  logic               found;
  logic [1:0]         found_d;
  logic               wrong_side;
  logic               straight;
  logic               limit_hit;

  assign in_cmd   = bct_pkg::cmd_t'(s_tuser);
  assign in_x     = s_tdata[8:0];
  assign in_y     = s_tdata[17:9];
  assign in_pix   = s_tdata[18];
  assign in_color = s_tdata[19];
  assign accept   = s_tvalid && s_tready;

  // out-of-range register values clamp into 1..max
  always_comb begin
    if (grid_width == '0) begin
      eff_w = CW'(1);
    end else if (grid_width > CW'(bct_pkg::MAX_WIDTH)) begin
      eff_w = CW'(bct_pkg::MAX_WIDTH);
    end else begin
      eff_w = grid_width;
    end
    if (grid_height == '0) begin
      eff_h = CW'(1);
    end else if (grid_height > CW'(bct_pkg::MAX_HEIGHT)) begin
      eff_h = CW'(bct_pkg::MAX_HEIGHT);
    end else begin
      eff_h = grid_height;
    end
  end

  assign start_off = (in_x > eff_w) || (in_y > eff_h);

  // one corner along the current heading
  always_comb begin
    cand_x = {1'b0, walk_x};
    cand_y = {1'b0, walk_y};
    case (heading)
      bct_pkg::HEAD_UP:    cand_y = {1'b0, walk_y} - (CW+1)'(1);
      bct_pkg::HEAD_RIGHT: cand_x = {1'b0, walk_x} + (CW+1)'(1);
      bct_pkg::HEAD_DOWN:  cand_y = {1'b0, walk_y} + (CW+1)'(1);
      default:             cand_x = {1'b0, walk_x} - (CW+1)'(1);
    endcase
  end

  assign at_origin = (cand_x == {1'b0, origin_x}) && (cand_y == {1'b0, origin_y});
  // negative shows up as the top bit
  assign cand_off  = cand_x[CW] || cand_y[CW] ||
                     (cand_x[CW-1:0] > eff_w) || (cand_y[CW-1:0] > eff_h);

  // quad in traced-color sense, then seen from the heading
  assign qc  = qrsp.quad ^ {4{~traced_color}};
  assign rot = bct_pkg::rotate_quad(qc, heading);

  // first heading with the traced region on the right and open on the left
  always_comb begin
    logic [3:0] r;
    found   = 1'b0;
    found_d = 2'd0;
    for (int d = 3; d >= 0; d--) begin
      r = bct_pkg::rotate_quad(qc, 2'(d));
      if (r[1:0] == 2'b10) begin
        found   = 1'b1;
        found_d = 2'(d);
      end
    end
  end

  // behind-right must be inside, behind-left outside
  assign wrong_side = (rot[3:2] != 2'b01);
  assign straight   = (rot[1:0] == 2'b10);
  assign limit_hit  = (step_cnt == bct_pkg::STEP_CNT_W'(bct_pkg::STEP_LIMIT - 1));

  assign out_free = !out_valid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bct_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            bct_pkg::CMD_START: state_next = start_off ? bct_pkg::S_EMIT : bct_pkg::S_ISSUE;
            bct_pkg::CMD_NEXT:  state_next = tracing_active ? bct_pkg::S_STEP : bct_pkg::S_EMIT;
            default:            state_next = bct_pkg::S_IDLE;
          endcase
        end
      end
      bct_pkg::S_STEP: begin
        state_next = (at_origin || cand_off) ? bct_pkg::S_EMIT : bct_pkg::S_ISSUE;
      end
      bct_pkg::S_ISSUE: begin
        state_next = bct_pkg::S_WAIT;
      end
      bct_pkg::S_WAIT: begin
        if (qrsp.done) begin
          if (!is_start && !wrong_side && straight && !limit_hit) begin
            state_next = bct_pkg::S_STEP;
          end else begin
            state_next = bct_pkg::S_EMIT;
          end
        end
      end
      bct_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = bct_pkg::S_IDLE;
        end
      end
      default: state_next = bct_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = (state == bct_pkg::S_IDLE);
    out_load   = (state == bct_pkg::S_EMIT) && out_free;
    qreq.go     = (state == bct_pkg::S_ISSUE);
    qreq.x      = walk_x;
    qreq.y      = walk_y;
    qreq.width  = eff_w;
    qreq.height = eff_h;
    // writes beyond the store are dropped
    mwr.en  = accept && (in_cmd == bct_pkg::CMD_WRITE) &&
              (in_x < CW'(bct_pkg::MAX_WIDTH)) && (in_y < CW'(bct_pkg::MAX_HEIGHT));
    mwr.x   = in_x[bct_pkg::XIDX_W-1:0];
    mwr.y   = in_y[bct_pkg::YIDX_W-1:0];
    mwr.pix = in_pix;
  end

  bct_quad_fetch u_fetch (
    .clk (clk),
    .rst (rst),
    .req (qreq),
    .wr  (mwr),
    .rsp (qrsp)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= bct_pkg::S_IDLE;
      grid_width     <= CW'(bct_pkg::MAX_WIDTH);
      grid_height    <= CW'(bct_pkg::MAX_HEIGHT);
      walk_x         <= '0;
      walk_y         <= '0;
      origin_x       <= '0;
      origin_y       <= '0;
      heading        <= bct_pkg::HEAD_UP;
      tracing_active <= 1'b0;
      traced_color   <= 1'b0;
      is_start       <= 1'b0;
      step_cnt       <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (bct_pkg::cfg_reg_t'(cfg_index))
          bct_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
          bct_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        bct_pkg::S_IDLE: begin
          if (accept && (in_cmd == bct_pkg::CMD_START)) begin
            // a failed start leaves tracing off, so loading the walk here is harmless
            walk_x         <= in_x;
            walk_y         <= in_y;
            origin_x       <= in_x;
            origin_y       <= in_y;
            traced_color   <= in_color;
            tracing_active <= 1'b0;
            is_start       <= 1'b1;
          end else if (accept && (in_cmd == bct_pkg::CMD_NEXT)) begin
            is_start <= 1'b0;
            step_cnt <= '0;
          end
        end
        bct_pkg::S_STEP: begin
          walk_x <= cand_x[CW-1:0];
          walk_y <= cand_y[CW-1:0];
          if (at_origin || cand_off) begin
            tracing_active <= 1'b0;
          end
        end
        bct_pkg::S_WAIT: begin
          if (qrsp.done) begin
            if (is_start) begin
              if (found) begin
                heading        <= found_d;
                tracing_active <= 1'b1;
              end
            end else if (wrong_side) begin
              tracing_active <= 1'b0;
            end else begin
              case (rot[1:0])
                2'b10: begin
                  step_cnt <= step_cnt + bct_pkg::STEP_CNT_W'(1);
                  if (limit_hit) begin
                    tracing_active <= 1'b0;
                  end
                end
                2'b11:   heading <= heading + 2'd3;  // left turn
                default: heading <= heading + 2'd1;  // right turn
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    case (state)
      bct_pkg::S_IDLE: begin
        res_done <= 1'b0;
        if (in_cmd == bct_pkg::CMD_START) begin
          res_x      <= in_x;
          res_y      <= in_y;
          res_status <= start_off ? bct_pkg::ST_OFF_GRID : bct_pkg::ST_OK;
        end else begin
          res_x      <= '0;
          res_y      <= '0;
          res_status <= bct_pkg::ST_NOT_TRACING;
        end
      end
      bct_pkg::S_STEP: begin
        if (at_origin) begin
          res_x      <= origin_x;
          res_y      <= origin_y;
          res_done   <= 1'b1;
          res_status <= bct_pkg::ST_OK;
        end else begin
          res_x      <= '0;
          res_y      <= '0;
          res_done   <= 1'b0;
          res_status <= bct_pkg::ST_OFF_GRID;
        end
      end
      bct_pkg::S_WAIT: begin
        if (qrsp.done) begin
          res_done <= 1'b0;
          if (is_start) begin
            res_status <= found ? bct_pkg::ST_OK : bct_pkg::ST_NO_HEADING;
          end else if (wrong_side) begin
            res_x      <= '0;
            res_y      <= '0;
            res_status <= bct_pkg::ST_WRONG_SIDE;
          end else if (straight) begin
            // only seen when the step limit ran out
            res_x      <= '0;
            res_y      <= '0;
            res_status <= bct_pkg::ST_OFF_GRID;
          end else begin
            res_x      <= walk_x;
            res_y      <= walk_y;
            res_status <= bct_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_x      <= res_x;
      out_y      <= res_y;
      out_done   <= res_done;
      out_status <= res_status;
    end
  end

  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {{(bct_pkg::OUT_DATA_W - 2 * CW){1'b0}}, out_y, out_x};
  assign m_tlast   = out_done;
  assign m_tuser   = out_status;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for bitmap_contour_tracer: directed and random command streams with a
// cycle-free predictor of the corner walk, checked beat by beat on the result stream
// depends on bct_pkg and the bitmap_contour_tracer rtl
`timescale 1ns / 100ps

module testbench;
  import bct_pkg::*;

  // cycles without any accepted beat before the run is declared hung; the slowest
  // next walks STEP_LIMIT corners, and receiver stalls add to that
  localparam int STALL_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 40;   // quiet time before register writes and at the end
  localparam int HOLD_OFF_CYCLES = 400;  // long receiver hold-off for the pressure test
  localparam int SEGMENT_ITEMS   = 75;   // random commands between grid changes

  // one result beat as the predictor expects it
  typedef struct packed {
    logic [8:0] vx;
    logic [8:0] vy;
    logic       done;
    status_t    st;
  } vertex_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;  // x_coord[8:0], y_coord[17:9], pixel_bit[18], target_color[19]
  logic [1:0]  s_tuser   = '0;  // command[1:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;         // vertex_x[8:0], vertex_y[17:9]
  logic        m_tlast;         // ring_done
  logic [2:0]  m_tuser;         // status[2:0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [8:0]  cfg_data  = '0;

  bitmap_contour_tracer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor state: mask copy, grid registers and the walk
  // ---------------------------------------------------------------------------
  bit         mask_bits [MAX_WIDTH*MAX_HEIGHT];
  logic [8:0] grid_w_reg = 9'd256;
  logic [8:0] grid_h_reg = 9'd256;
  int         pos_x, pos_y;    // current walk corner
  int         home_x, home_y;  // corner the ring started from
  heading_t   dir = HEAD_UP;
  bit         tracing;
  logic       trace_color;

  vertex_t    awaited_vertices[$];

  // knobs and bookkeeping shared by the stimulus processes
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;  // bumped by a test to start a receiver hold-off
  int hold_seen      = 0;
  int hold_left      = 0;
  int items_sent     = 0;
  int error_count    = 0;
  int stuck_cycles   = 0;

  // registers out of range clamp to 1..MAX
  function automatic int span_w();
    if (grid_w_reg == 0) return 1;
    if (grid_w_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(grid_w_reg);
  endfunction

  function automatic int span_h();
    if (grid_h_reg == 0) return 1;
    if (grid_h_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return int'(grid_h_reg);
  endfunction

  // pixels outside the grid window read as 0
  function automatic bit pixel_value(int x, int y);
    if (x < 0 || y < 0 || x >= span_w() || y >= span_h()) return 1'b0;
    return mask_bits[y*MAX_WIDTH + x];
  endfunction

  // 2x2 quad around a corner: bit0 up-left, bit1 up-right, bit2 down-right,
  // bit3 down-left; inverted when tracing the 0 color
  function automatic logic [3:0] corner_pixels(int x, int y, logic color);
    logic [3:0] q;
    q = {pixel_value(x-1, y), pixel_value(x, y), pixel_value(x, y-1), pixel_value(x-1, y-1)};
    return color ? q : ~q;
  endfunction

  // quad as seen when facing heading d
  function automatic logic [3:0] heading_view(logic [3:0] q, logic [1:0] d);
    logic [3:0] r;
    for (int i = 0; i < 4; i++) r[i] = q[(i + d) % 4];
    return r;
  endfunction

  function automatic vertex_t trace_start(logic [8:0] x, logic [8:0] y, logic color);
    vertex_t    v;
    logic [3:0] q;
    logic [3:0] seen;
    bit         found;
    tracing = 1'b0;
    v.vx    = x;
    v.vy    = y;
    v.done  = 1'b0;
    if (x > span_w() || y > span_h()) begin
      v.st = ST_OFF_GRID;
      return v;
    end
    q     = corner_pixels(x, y, color);
    found = 1'b0;
    // first heading, counting up from up, with region on the right hand
    for (int d = 0; d < 4 && !found; d++) begin
      seen = heading_view(q, d[1:0]);
      if (seen[1:0] == 2'b10) begin
        found = 1'b1;
        dir   = heading_t'(d[1:0]);
      end
    end
    if (!found) begin
      v.st = ST_NO_HEADING;
      return v;
    end
    pos_x       = x;
    pos_y       = y;
    home_x      = x;
    home_y      = y;
    trace_color = color;
    tracing     = 1'b1;
    v.st        = ST_OK;
    return v;
  endfunction

  // walk straight until the next turning corner, the start corner or an error
  function automatic vertex_t trace_next();
    vertex_t    v;
    logic [3:0] q;
    v = '{vx: 9'd0, vy: 9'd0, done: 1'b0, st: ST_NOT_TRACING};
    if (!tracing) return v;
    for (int n = 0; n < STEP_LIMIT; n++) begin
      case (dir)
        HEAD_UP:    pos_y--;
        HEAD_RIGHT: pos_x++;
        HEAD_DOWN:  pos_y++;
        default:    pos_x--;
      endcase
      if (pos_x == home_x && pos_y == home_y) begin
        tracing = 1'b0;
        v.vx    = home_x[8:0];
        v.vy    = home_y[8:0];
        v.done  = 1'b1;
        v.st    = ST_OK;
        return v;
      end
      if (pos_x < 0 || pos_y < 0 || pos_x > span_w() || pos_y > span_h()) break;
      q = heading_view(corner_pixels(pos_x, pos_y, trace_color), dir);
      // pixels behind must be region on the right, outside on the left
      if (q[3:2] != 2'b01) begin
        tracing = 1'b0;
        v.st    = ST_WRONG_SIDE;
        return v;
      end
      if (q[1:0] != 2'b10) begin
        // both ahead in region turns left, otherwise right
        dir  = heading_t'((q[1:0] == 2'b11) ? dir + 2'd3 : dir + 2'd1);
        v.vx = pos_x[8:0];
        v.vy = pos_y[8:0];
        v.st = ST_OK;
        return v;
      end
    end
    tracing = 1'b0;
    v.st    = ST_OFF_GRID;
    return v;
  endfunction

  function automatic void apply_command(cmd_t cmd, logic [8:0] x, logic [8:0] y,
                                        logic pix, logic color);
    case (cmd)
      CMD_WRITE: begin
        // writes beyond the store are dropped
        if (x < MAX_WIDTH && y < MAX_HEIGHT) mask_bits[y*MAX_WIDTH + x] = pix;
      end
      CMD_START: awaited_vertices.push_back(trace_start(x, y, color));
      CMD_NEXT:  awaited_vertices.push_back(trace_next());
      default:   ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // offer one command beat, with random idle cycles ahead of it; valid stays up
  // after the handshake so that back-to-back beats never toggle it in one step
  task automatic send_command(cmd_t cmd, logic [8:0] x, logic [8:0] y,
                              logic pix, logic color);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, color, pix, y, x};
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_command(cmd, x, y, pix, color);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // drop valid, let every expected result drain, then wait out the settle time
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (awaited_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both grid registers, back to back on the register channel
  task automatic set_grid(logic [8:0] w, logic [8:0] h);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_w_reg = w;
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_h_reg = h;
    cfg_valid <= 1'b0;
  endtask

  // follow the current ring with next commands; sometimes a pixel next to the
  // walk is rewritten first so that the walk can end up on the wrong side
  task automatic trace_ring(int max_steps, int write_pct);
    int wx, wy;
    for (int n = 0; n < max_steps && tracing; n++) begin
      if ($urandom_range(99) < write_pct) begin
        wx = pos_x - int'($urandom_range(1));
        wy = pos_y - int'($urandom_range(1));
        if (wx >= 0 && wy >= 0)
          send_command(CMD_WRITE, wx[8:0], wy[8:0], 1'($urandom_range(1)), 1'b0);
      end
      send_command(CMD_NEXT, 9'($urandom_range(256)), 9'($urandom_range(256)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  function automatic logic [8:0] pick_extent();
    case ($urandom_range(9))
      0:       return 9'd0;                         // acts as 1
      1:       return 9'($urandom_range(257, 511)); // acts as the maximum
      2:       return 9'd256;
      default: return 9'($urandom_range(1, 12));
    endcase
  endfunction

  // mostly near the top-left where shapes live, one past the grid edge included
  function automatic logic [8:0] pick_coord(int extent);
    int reach;
    reach = (extent < 14) ? extent + 1 : 15;
    if ($urandom_range(15) == 0) return 9'($urandom_range(256));
    return 9'($urandom_range(reach));
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // every store entry gets a defined value before anything reads the mask
  task automatic clear_mask_store();
    for (int y = 0; y < MAX_HEIGHT; y++)
      for (int x = 0; x < MAX_WIDTH; x++)
        send_command(CMD_WRITE, 9'(x), 9'(y), 1'b0, 1'b0);
  endtask

  task automatic test_directed_commands();
    set_grid(9'd8, 9'd8);
    // next with no trace running
    send_command(CMD_NEXT, 9'd0, 9'd0, 1'b0, 1'b0);
    // small L shape, traced from its top-left corner as a full ring
    send_command(CMD_WRITE, 9'd3, 9'd3, 1'b1, 1'b0);
    send_command(CMD_WRITE, 9'd4, 9'd3, 1'b1, 1'b0);
    send_command(CMD_WRITE, 9'd4, 9'd4, 1'b1, 1'b0);
    send_command(CMD_START, 9'd3, 9'd3, 1'b0, 1'b1);
    trace_ring(12, 0);
    // same corner, background color
    send_command(CMD_START, 9'd3, 9'd3, 1'b1, 1'b0);
    trace_ring(4, 0);
    // start corners past the grid in either direction
    send_command(CMD_START, 9'd9, 9'd3, 1'b0, 1'b1);
    send_command(CMD_START, 9'd3, 9'd9, 1'b0, 1'b1);
    // uniform quad gives no start heading
    send_command(CMD_START, 9'd0, 9'd0, 1'b0, 1'b1);
    // writes beyond the store are dropped, one inside the store but off grid reads 0
    send_command(CMD_WRITE, 9'd256, 9'd3, 1'b1, 1'b1);
    send_command(CMD_WRITE, 9'd3, 9'd256, 1'b1, 1'b1);
    send_command(CMD_WRITE, 9'd8, 9'd2, 1'b1, 1'b0);
    send_command(CMD_START, 9'd8, 9'd2, 1'b0, 1'b1);
    // unused command: no result
    send_command(CMD_UNUSED, 9'd5, 9'd5, 1'b1, 1'b1);
    send_command(CMD_NEXT, 9'd0, 9'd0, 1'b0, 1'b0);
  endtask

  task automatic test_grid_extremes();
    // zero acts as a one-pixel grid
    set_grid(9'd0, 9'd0);
    send_command(CMD_WRITE, 9'd0, 9'd0, 1'b1, 1'b0);
    send_command(CMD_START, 9'd0, 9'd0, 1'b0, 1'b1);
    trace_ring(8, 0);
    send_command(CMD_START, 9'd2, 9'd1, 1'b0, 1'b1);
    // above the maximum acts as the full store, trace at the far corner
    set_grid(9'd511, 9'd511);
    send_command(CMD_WRITE, 9'd255, 9'd255, 1'b1, 1'b0);
    send_command(CMD_START, 9'd256, 9'd256, 1'b0, 1'b1);
    trace_ring(8, 0);
    send_command(CMD_START, 9'd257, 9'd0, 1'b0, 1'b1);
    // one column of full height
    set_grid(9'd1, 9'd256);
    send_command(CMD_WRITE, 9'd0, 9'd255, 1'b1, 1'b0);
    send_command(CMD_START, 9'd0, 9'd256, 1'b0, 1'b1);
    trace_ring(8, 0);
    set_grid(9'd256, 9'd256);
  endtask

  // receiver holds off while rings keep coming, so the block fills and stalls input
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_grid(9'd6, 9'd6);
    send_command(CMD_WRITE, 9'd1, 9'd1, 1'b1, 1'b0);
    send_command(CMD_WRITE, 9'd2, 9'd1, 1'b1, 1'b0);
    send_command(CMD_WRITE, 9'd1, 9'd2, 1'b1, 1'b0);
    send_command(CMD_WRITE, 9'd2, 9'd2, 1'b1, 1'b0);
    hold_req++;
    repeat (3) begin
      send_command(CMD_START, 9'd1, 9'd1, 1'b0, 1'b1);
      trace_ring(8, 0);
    end
    wait_idle();
  endtask

  // well-formed start-and-walk sequences with random shapes, plus some noise
  task automatic test_random_walks();
    int base;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      repeat (2) begin
        set_grid(pick_extent(), pick_extent());
        base = items_sent;
        while (items_sent - base < SEGMENT_ITEMS) begin
          if ($urandom_range(9) < 7) begin
            repeat ($urandom_range(5))
              send_command(CMD_WRITE, pick_coord(span_w()), pick_coord(span_h()),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            send_command(CMD_START, pick_coord(span_w()), pick_coord(span_h()),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            trace_ring(40, 8);
          end else begin
            send_command(cmd_t'($urandom_range(3)), 9'($urandom_range(256)),
                         9'($urandom_range(256)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    clear_mask_store();
    test_directed_commands();
    test_grid_extremes();
    test_backpressure();
    test_random_walks();
    wait_idle();
    if (error_count == 0) begin
      $display("bitmap_contour_tracer verification clean");
    end else begin
      $display("bitmap_contour_tracer verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random stalls, or a counted hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each result beat with the oldest expected vertex
  always @(posedge clk) begin : check_beat
    vertex_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_vertices.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result beat x=%0d y=%0d last=%b status=%0d",
                 $time, m_tdata[8:0], m_tdata[17:9], m_tlast, m_tuser);
      end else begin
        want = awaited_vertices.pop_front();
        if (m_tdata[8:0] !== want.vx || m_tdata[17:9] !== want.vy ||
            m_tlast !== want.done || m_tuser !== want.st) begin
          error_count++;
          $display("%0t: expected x=%0d y=%0d last=%b status=%0d, got x=%0d y=%0d last=%b status=%0d",
                   $time, want.vx, want.vy, want.done, want.st,
                   m_tdata[8:0], m_tdata[17:9], m_tlast, m_tuser);
        end
      end
    end
  end

  // hang detection: any accepted beat on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("bitmap_contour_tracer verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule
